/* sv/itsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package itsc_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [CharW-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;

  localparam logic REG_ALLOW_SIGN     = 1'b0;
  localparam logic REG_REQUIRE_COMMAS = 1'b1;

  typedef struct packed {
    logic allow_sign;
    logic require_commas;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic well_formed;
  } scan_res_t;

endpackage

`default_nettype wire

/* sv/itsc_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module itsc_cfg
  import itsc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_ALLOW_SIGN:     cfg_nxt.allow_sign     = pwdata[0];
        REG_REQUIRE_COMMAS: cfg_nxt.require_commas = pwdata[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_ALLOW_SIGN:     prdata[0] = cfg_r.allow_sign;
      REG_REQUIRE_COMMAS: prdata[0] = cfg_r.require_commas;
      default:            prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* sv/itsc_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

module itsc_scan
  import itsc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CharW-1:0] in_character,
  input  wire logic             in_end_of_string,
  output scan_res_t             res,
  input  wire logic             res_ready
);

  localparam logic [PhaseW-1:0] PH_START  = 4'd0;
  localparam logic [PhaseW-1:0] PH_MINUS  = 4'd1;
  localparam logic [PhaseW-1:0] PH_ZERO   = 4'd2;
  localparam logic [PhaseW-1:0] PH_PLAIN  = 4'd3;
  localparam logic [PhaseW-1:0] PH_HEAD1  = 4'd4;
  localparam logic [PhaseW-1:0] PH_HEAD2  = 4'd5;
  localparam logic [PhaseW-1:0] PH_HEAD3  = 4'd6;
  localparam logic [PhaseW-1:0] PH_GRP0   = 4'd7;
  localparam logic [PhaseW-1:0] PH_GRP1   = 4'd8;
  localparam logic [PhaseW-1:0] PH_GRP2   = 4'd9;
  localparam logic [PhaseW-1:0] PH_GRP3   = 4'd10;
  localparam logic [PhaseW-1:0] PH_REJECT = 4'd11;

  logic              stg_valid_r;
  logic              stg_valid_nxt;
  logic [CharW-1:0]  stg_char_r;
  logic              stg_eos_r;
  logic [PhaseW-1:0] phase_r;
  logic [PhaseW-1:0] phase_nxt;
  logic [PhaseW-1:0] adv_phase;
  logic [PhaseW-1:0] first_phase;
  logic              stg_go;
  logic              is_dig;
  logic              is_comma;
  logic              is_minus;
  logic              is_zero;

  assign stg_go   = stg_valid_r && (!stg_eos_r || res_ready);
  assign in_ready = !stg_valid_r || stg_go;

  assign is_dig      = stg_char_r inside {[CHAR_ZERO:CHAR_NINE]};
  assign is_comma    = (stg_char_r == CHAR_COMMA);
  assign is_minus    = (stg_char_r == CHAR_MINUS);
  assign is_zero     = (stg_char_r == CHAR_ZERO);
  assign first_phase = cfg.require_commas ? PH_HEAD1 : PH_PLAIN;

  always_comb begin
    case (phase_r)
      PH_START: begin
        if (is_minus && cfg.allow_sign) begin
          adv_phase = PH_MINUS;
        end else if (is_zero) begin
          adv_phase = PH_ZERO;
        end else if (is_dig) begin
          adv_phase = first_phase;
        end else begin
          adv_phase = PH_REJECT;
        end
      end
      PH_MINUS: adv_phase = (is_dig && !is_zero) ? first_phase : PH_REJECT;
      PH_PLAIN: adv_phase = is_dig ? PH_PLAIN : PH_REJECT;
      PH_HEAD1: begin
        if (is_dig) begin
          adv_phase = PH_HEAD2;
        end else begin
          adv_phase = is_comma ? PH_GRP0 : PH_REJECT;
        end
      end
      PH_HEAD2: begin
        if (is_dig) begin
          adv_phase = PH_HEAD3;
        end else begin
          adv_phase = is_comma ? PH_GRP0 : PH_REJECT;
        end
      end
      PH_HEAD3, PH_GRP3: adv_phase = is_comma ? PH_GRP0 : PH_REJECT;
      PH_GRP0:  adv_phase = is_dig ? PH_GRP1 : PH_REJECT;
      PH_GRP1:  adv_phase = is_dig ? PH_GRP2 : PH_REJECT;
      PH_GRP2:  adv_phase = is_dig ? PH_GRP3 : PH_REJECT;
      default:  adv_phase = PH_REJECT;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    if (stg_go) begin
      phase_nxt = stg_eos_r ? PH_START : adv_phase;
    end
  end

  assign stg_valid_nxt = in_ready ? in_valid : stg_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      phase_r     <= PH_START;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_char_r <= in_character;
      stg_eos_r  <= in_end_of_string;
    end
  end

  assign res.valid       = stg_valid_r && stg_eos_r;
  assign res.well_formed = phase_r inside {PH_ZERO, PH_PLAIN, PH_HEAD1, PH_HEAD2,
                                           PH_HEAD3, PH_GRP3};

endmodule

`default_nettype wire

/* sv/integer_text_syntax_checker_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Checks that a stream of characters, one per transfer and closed by a transfer with
// in_end_of_string set, forms a well-formed decimal integer: a plain digit string, or
// comma-grouped digits when require_commas is set, with an optional leading minus when
// allow_sign is set. Only the closing transfer produces a result, out_well_formed; out_valid
// rises once the closing transfer has passed the input register and the output register is
// free. One character is accepted every cycle while the input does not stall; that rate is
// set by the scan phase register, which is updated once per character by combinational
// next-state logic. While a result waits on the output, characters keep flowing, and the
// input stalls only when a second closing transfer reaches the input register. Registers:
// allow_sign at byte address 0 and require_commas at byte address 4, both bit 0.
module integer_text_syntax_checker_top
  import itsc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CharW-1:0] in_character,
  input  wire logic             in_end_of_string,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_well_formed
);

  cfg_t      cfg;
  scan_res_t res;
  logic      res_ready;
  logic      out_valid_r;
  logic      out_valid_nxt;
  logic      out_wf_r;

  itsc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  itsc_scan u_scan (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_character     (in_character),
    .in_end_of_string (in_end_of_string),
    .res              (res),
    .res_ready        (res_ready)
  );

  assign res_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = res_ready ? res.valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_wf_r <= res.well_formed;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_well_formed = out_wf_r;

`ifndef NO_ASSERTIONS
  a_stall_only_on_full_output: assert property (
    @(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && res.valid))
    else $error("input stalled without a waiting result");

  a_reset_clears_output: assert property (
    @(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid directly after reset");

  a_result_moves_when_free: assert property (
    @(posedge clk) disable iff (!rst_n)
    (res.valid && !out_valid) |=> out_valid)
    else $error("pending result not moved to a free output register");
`endif

endmodule

`default_nettype wire
